// ===== sv/rational_arith_unit_macros.svh =====
// ---------------------------------------------------------------------------
// rational_arith_unit_macros: assertion macros
// Concurrent assertion wrappers clocked on clk; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
`ifndef SYNTH
// check outside reset
`define RAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rational_arith_unit assertion failed");
// check that also covers reset cycles
`define RAU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rational_arith_unit reset assertion failed");
`else
`define RAU_ASSERT(lbl, prop)
`define RAU_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/rau_pkg.sv =====
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants
// Operation codes, status codes, datapath command and status groups.
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH = 32;
  // largest reduced magnitude that fits, and mask of WIDTH-1 bits
  localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

  typedef enum logic [2:0] {
    REQ_ADD = 3'd0,
    REQ_SUB = 3'd1,
    REQ_MUL = 3'd2,
    REQ_DIV = 3'd3,
    REQ_CMP = 3'd4
  } req_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_SUM,
    DP_GCD,
    DP_DIVN_INIT,
    DP_DIVD_INIT,
    DP_DIV_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_arith;
    logic addsub;
    logic zero_case;
    logic gcd_done;
    logic div_last;
  } dp_stat_t;

endpackage

// ===== sv/rau_datapath.sv =====
// ---------------------------------------------------------------------------
// rau_datapath: products, binary GCD, restoring divider, result registers
// Executes one command per cycle from the controller.
// ---------------------------------------------------------------------------
module rau_datapath (
  input  logic               clk,
  input  rau_pkg::dp_cmd_t   cmd,
  output rau_pkg::dp_stat_t  stat,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               is_equal,
  output logic [1:0]         status
);

  logic [2:0]  op;
  logic [31:0] an_m, ad_m, bn_m, bd_m;
  logic        an_s, ad_s, bn_s, bd_s;
  logic        eq;
  logic [63:0] pn, pd, pt;
  logic [63:0] nm, dm;
  logic        neg;
  logic [63:0] gx, gy;
  logic [5:0]  k;
  logic [63:0] dv, rem, q, qn;
  logic [5:0]  cnt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        xs, ts, ns, ds;
  logic [63:0] sum_m;
  logic [64:0] sh;
  logic        ge;
  logic [63:0] nval, sx;
  logic        ovf;

  logic signed [31:0] res_num_next;
  logic [30:0]        res_den_next;
  logic               is_equal_next;
  logic [1:0]         status_next;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_a = an_m;
    mul_b = bd_m;
    unique case (cmd.op)
      rau_pkg::DP_MUL0: begin
        mul_a = an_m;
        mul_b = (op == rau_pkg::REQ_MUL) ? bn_m : bd_m;
      end
      rau_pkg::DP_MUL1: begin
        mul_a = ad_m;
        mul_b = (op == rau_pkg::REQ_DIV) ? bn_m : bd_m;
      end
      rau_pkg::DP_MUL2: begin
        mul_a = bn_m;
        mul_b = ad_m;
      end
      default: begin
        mul_a = an_m;
        mul_b = bd_m;
      end
    endcase
  end
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // signed-magnitude sum of the two cross products for add/subtract; first product otherwise
  always_comb begin
    xs    = an_s ^ ((op == rau_pkg::REQ_MUL) ? bn_s : bd_s);
    ts    = bn_s ^ ad_s ^ (op == rau_pkg::REQ_SUB);
    ds    = ad_s ^ ((op == rau_pkg::REQ_DIV) ? bn_s : bd_s);
    sum_m = pn;
    ns    = xs;
    if (op == rau_pkg::REQ_ADD || op == rau_pkg::REQ_SUB) begin
      if (xs == ts) begin
        sum_m = pn + pt;
      end else if (pn >= pt) begin
        sum_m = pn - pt;
      end else begin
        sum_m = pt - pn;
        ns    = ts;
      end
    end
  end

  assign sh = {rem, q[63]};
  assign ge = sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rau_pkg::DP_LOAD: begin
        op   <= req_type;
        an_m <= mag(a_num);
        ad_m <= mag(a_den);
        bn_m <= mag(b_num);
        bd_m <= mag(b_den);
        an_s <= a_num[31];
        ad_s <= a_den[31];
        bn_s <= b_num[31];
        bd_s <= b_den[31];
        eq   <= (a_num == b_num) && (a_den == b_den);
      end
      rau_pkg::DP_MUL0: pn <= prod;
      rau_pkg::DP_MUL1: pd <= prod;
      rau_pkg::DP_MUL2: pt <= prod;
      rau_pkg::DP_SUM: begin
        nm  <= sum_m;
        dm  <= pd;
        neg <= ns ^ ds;
        gx  <= sum_m;
        gy  <= pd;
        k   <= '0;
      end
      rau_pkg::DP_GCD: begin
        if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          k  <= k + 6'd1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= gx - gy;
        end else begin
          gx <= gy - gx;
          gy <= gx;
        end
      end
      rau_pkg::DP_DIVN_INIT: begin
        dv  <= gy << k;
        q   <= nm;
        rem <= '0;
        cnt <= '0;
      end
      rau_pkg::DP_DIVD_INIT: begin
        qn  <= q;
        q   <= dm;
        rem <= '0;
        cnt <= '0;
      end
      rau_pkg::DP_DIV_STEP: begin
        rem <= ge ? 64'(sh - {1'b0, dv}) : sh[63:0];
        q   <= {q[62:0], ge};
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

  // final sign, overflow check and truncation
  always_comb begin
    nval = neg ? (~qn + 64'd1) : qn;
    ovf  = (neg ? (qn > rau_pkg::LIM + 64'd1) : (qn > rau_pkg::LIM)) || (q > rau_pkg::LIM);
    for (int i = 0; i < 64; i++) begin
      sx[i] = (i < rau_pkg::WIDTH) ? nval[i] : nval[rau_pkg::WIDTH - 1];
    end
  end

  // result fields by case
  always_comb begin
    res_num_next  = '0;
    res_den_next  = '0;
    is_equal_next = 1'b0;
    status_next   = rau_pkg::ST_OK;
    priority if (op == rau_pkg::REQ_CMP) begin
      is_equal_next = eq;
    end else if (op > rau_pkg::REQ_CMP) begin
      status_next = rau_pkg::ST_OK;
    end else if (dm == 64'd0) begin
      status_next = rau_pkg::ST_ZDEN;
    end else if (nm == 64'd0) begin
      res_den_next = 31'd1;
    end else begin
      res_num_next = sx[31:0];
      res_den_next = 31'(q & rau_pkg::LIM);
      status_next  = ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num  <= res_num_next;
      res_den  <= res_den_next;
      is_equal <= is_equal_next;
      status   <= status_next;
    end
  end

  assign stat.in_arith  = req_type < rau_pkg::REQ_CMP;
  assign stat.addsub    = (op == rau_pkg::REQ_ADD) || (op == rau_pkg::REQ_SUB);
  assign stat.zero_case = (nm == 64'd0) || (dm == 64'd0);
  assign stat.gcd_done  = gx == 64'd0;
  assign stat.div_last  = cnt == 6'd63;

endmodule

// ===== sv/rau_ctrl.sv =====
// ---------------------------------------------------------------------------
// rau_ctrl: sequencer for the rational arithmetic unit
// Steps the datapath through products, GCD and divisions; owns the handshakes.
// ---------------------------------------------------------------------------
`include "rational_arith_unit_macros.svh"
module rau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MUL0   = 11'b00000000010,
    S_MUL1   = 11'b00000000100,
    S_MUL2   = 11'b00000001000,
    S_SUM    = 11'b00000010000,
    S_GCD    = 11'b00000100000,
    S_DINITN = 11'b00001000000,
    S_DSTEPN = 11'b00010000000,
    S_DINITD = 11'b00100000000,
    S_DSTEPD = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd.op       = rau_pkg::DP_NOP;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = rau_pkg::DP_LOAD;
          state_next = stat.in_arith ? S_MUL0 : S_FIN;
        end
      end
      S_MUL0: begin
        cmd.op     = rau_pkg::DP_MUL0;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = rau_pkg::DP_MUL1;
        state_next = stat.addsub ? S_MUL2 : S_SUM;
      end
      S_MUL2: begin
        cmd.op     = rau_pkg::DP_MUL2;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = rau_pkg::DP_SUM;
        state_next = S_GCD;
      end
      S_GCD: begin
        priority if (stat.zero_case) begin
          state_next = S_FIN;
        end else if (stat.gcd_done) begin
          state_next = S_DINITN;
        end else begin
          cmd.op = rau_pkg::DP_GCD;
        end
      end
      S_DINITN: begin
        cmd.op     = rau_pkg::DP_DIVN_INIT;
        state_next = S_DSTEPN;
      end
      S_DSTEPN: begin
        cmd.op = rau_pkg::DP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_DINITD;
        end
      end
      S_DINITD: begin
        cmd.op     = rau_pkg::DP_DIVD_INIT;
        state_next = S_DSTEPD;
      end
      S_DSTEPD: begin
        cmd.op = rau_pkg::DP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RAU_ASSERT(a_fin_hold, (state == S_FIN && out_valid && out_stall) |=> state == S_FIN)
  `RAU_ASSERT(a_accept_busy, accept |=> state != S_IDLE)
  `RAU_ASSERT(a_no_overwrite, !(cmd.out_load && out_valid && out_stall))
  `RAU_ASSERT_RST(a_reset_clear, rst |=> (state == S_IDLE && !out_valid))

endmodule

// ===== sv/rational_arith_unit.sv =====
// ---------------------------------------------------------------------------
// rational_arith_unit: exact add, subtract, multiply, divide, compare of fractions
// Sequence: compare and unused codes load, then output; arithmetic runs the products
//   (a third for add/sub), a sum, binary-GCD steps, two restoring divisions, output.
// Throughput: one beat at a time, set by the GCD loop and the shared 1-bit divider.
// A new beat is taken while the previous result still waits on out_stall.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
// ---------------------------------------------------------------------------
module rational_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               is_equal,
  output logic [1:0]         status
);

  // command and status between the sequencer and the datapath
  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;

  // sequencer: handshakes and step order
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: one shared multiplier, GCD registers, divider, output register
  rau_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .req_type (req_type),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .res_num  (res_num),
    .res_den  (res_den),
    .is_equal (is_equal),
    .status   (status)
  );

endmodule
